// File: hdl/trsa_pkg.sv
// Package for the temporary register slot allocator.
// Holds table sizes, command, action and datapath operation codes, shared types
// and the slot-to-register mapping. Depends on nothing.
`timescale 1ns / 1ps

package trsa_pkg;

    localparam int SLOTS     = 16;
    localparam int NAME_BITS = 16;
    localparam int AGE_BITS  = 16;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOTS_P2  = 1 << IDX_W;

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    localparam logic [4:0] REG_T0        = 5'd7;
    localparam logic [4:0] REG_T9        = 5'd16;
    localparam logic [5:0] REG_LO_BASE   = 6'd7;
    localparam logic [5:0] REG_SPLIT     = 6'd8;
    localparam logic [5:0] REG_HI_OFFSET = 6'd9;

    typedef logic [NAME_BITS-1:0] t_name;
    typedef logic [AGE_BITS-1:0]  t_age;
    typedef logic [IDX_W-1:0]     t_idx;

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_STORE = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ACT_DEFAULT     = 4'd0,
        ACT_HIT         = 4'd1,
        ACT_FILL_FREE   = 4'd2,
        ACT_SPILL_VICT  = 4'd3,
        ACT_FILL_VICT   = 4'd4,
        ACT_MEM_DEFAULT = 4'd5,
        ACT_COPY_SLOT   = 4'd6,
        ACT_CLEAR_SPILL = 4'd7,
        ACT_CLEAR_DONE  = 4'd8
    } t_action;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_DECIDE,
        OP_SEARCH,
        OP_SPILL,
        OP_FILL,
        OP_WALK,
        OP_DONE
    } t_dp_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_SPILL,
        ST_FILL,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic spill;
        logic full_miss;
        logic walk_last;
    } t_dp_status;

    function automatic logic [4:0] reg_of(input t_idx j);
        logic [5:0] r;
        if (6'(j) < REG_SPLIT) begin
            r = REG_LO_BASE + 6'(j);
        end else begin
            r = 6'(j) + REG_HI_OFFSET;
        end
        return r[4:0];
    endfunction

endpackage

// File: hdl/trsa_ctrl.sv
// Controller state machine of the slot allocator.
// Sequences decode, victim search, spill and fill, and the clear walk.
// Depends on trsa_pkg.
`timescale 1ns / 1ps

module trsa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  trsa_pkg::t_dp_status  i_status,
    output logic                  o_busy,
    output trsa_pkg::t_dp_op      o_op
);

    trsa_pkg::t_state r_state;
    trsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trsa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            trsa_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = trsa_pkg::ST_DECODE;
                end
            end
            trsa_pkg::ST_DECODE: begin
                if (i_status.clear) begin
                    n_state = i_status.spill ? trsa_pkg::ST_WALK : trsa_pkg::ST_DONE;
                end else if (i_status.full_miss) begin
                    n_state = trsa_pkg::ST_SEARCH;
                end else begin
                    n_state = trsa_pkg::ST_IDLE;
                end
            end
            trsa_pkg::ST_SEARCH: n_state = trsa_pkg::ST_SPILL;
            trsa_pkg::ST_SPILL:  n_state = trsa_pkg::ST_FILL;
            trsa_pkg::ST_FILL:   n_state = trsa_pkg::ST_IDLE;
            trsa_pkg::ST_WALK: begin
                if (i_status.walk_last) begin
                    n_state = trsa_pkg::ST_DONE;
                end
            end
            trsa_pkg::ST_DONE:   n_state = trsa_pkg::ST_IDLE;
            default:             n_state = trsa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != trsa_pkg::ST_IDLE);
        case (r_state)
            trsa_pkg::ST_IDLE:   o_op = i_start ? trsa_pkg::OP_LATCH : trsa_pkg::OP_NONE;
            trsa_pkg::ST_DECODE: o_op = trsa_pkg::OP_DECIDE;
            trsa_pkg::ST_SEARCH: o_op = trsa_pkg::OP_SEARCH;
            trsa_pkg::ST_SPILL:  o_op = trsa_pkg::OP_SPILL;
            trsa_pkg::ST_FILL:   o_op = trsa_pkg::OP_FILL;
            trsa_pkg::ST_WALK:   o_op = trsa_pkg::OP_WALK;
            trsa_pkg::ST_DONE:   o_op = trsa_pkg::OP_DONE;
            default:             o_op = trsa_pkg::OP_NONE;
        endcase
    end

endmodule

// File: hdl/trsa_datapath.sv
// Datapath of the slot allocator: slot table, tag compare, age update,
// oldest-slot search tree and registered result outputs.
// Depends on trsa_pkg.
`timescale 1ns / 1ps

module trsa_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  trsa_pkg::t_dp_op      i_op,
    input  logic [1:0]            i_cmd,
    input  logic [15:0]           i_name_id,
    input  logic                  i_is_temp,
    input  logic [4:0]            i_default_reg,
    input  logic                  i_spill_on_clear,
    output trsa_pkg::t_dp_status  o_status,
    output logic                  o_strobe,
    output logic [3:0]            o_action,
    output logic [4:0]            o_reg_number,
    output logic [15:0]           o_spill_name,
    output logic                  o_last
);

    trsa_pkg::t_cmd    r_cmd, n_cmd;
    trsa_pkg::t_name   r_name, n_name;
    logic              r_temp, n_temp;
    logic [4:0]        r_dflt, n_dflt;
    logic              r_spill, n_spill;

    trsa_pkg::t_name   r_slot_name [trsa_pkg::SLOTS];
    trsa_pkg::t_name   n_slot_name [trsa_pkg::SLOTS];
    trsa_pkg::t_age    r_slot_age  [trsa_pkg::SLOTS];
    trsa_pkg::t_age    n_slot_age  [trsa_pkg::SLOTS];
    logic [trsa_pkg::SLOTS-1:0] r_slot_valid, n_slot_valid;
    trsa_pkg::t_idx    r_idx, n_idx;

    logic              r_strobe, n_strobe;
    trsa_pkg::t_action r_action, n_action;
    logic [4:0]        r_reg, n_reg;
    logic [15:0]       r_spill_name, n_spill_name;
    logic              r_last, n_last;

    logic              hit;
    trsa_pkg::t_idx    hit_idx;
    logic              has_free;
    trsa_pkg::t_idx    free_idx;
    logic              is_clear;
    logic              lookup_only;
    trsa_pkg::t_name   sel_name;

    trsa_pkg::t_age    tree_age [trsa_pkg::IDX_W+1][trsa_pkg::SLOTS_P2];
    trsa_pkg::t_idx    tree_idx [trsa_pkg::IDX_W+1][trsa_pkg::SLOTS_P2];
    trsa_pkg::t_idx    max_idx;

    assign is_clear    = (r_cmd == trsa_pkg::CMD_CLEAR);
    assign lookup_only = (r_cmd == trsa_pkg::CMD_LOAD) &&
                         ((r_dflt < trsa_pkg::REG_T0) || (r_dflt > trsa_pkg::REG_T9));
    assign sel_name    = r_slot_name[r_idx];

    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int j = trsa_pkg::SLOTS - 1; j >= 0; j--) begin
            if (r_slot_valid[j] && (r_slot_name[j] == r_name)) begin
                hit     = 1'b1;
                hit_idx = trsa_pkg::IDX_W'(j);
            end
            if (!r_slot_valid[j]) begin
                has_free = 1'b1;
                free_idx = trsa_pkg::IDX_W'(j);
            end
        end
    end

    // oldest slot, lowest index on ties
    always_comb begin
        for (int l = 0; l <= trsa_pkg::IDX_W; l++) begin
            for (int k = 0; k < trsa_pkg::SLOTS_P2; k++) begin
                tree_age[l][k] = '0;
                tree_idx[l][k] = '0;
            end
        end
        for (int k = 0; k < trsa_pkg::SLOTS_P2; k++) begin
            tree_idx[0][k] = trsa_pkg::IDX_W'(k);
            if (k < trsa_pkg::SLOTS) begin
                tree_age[0][k] = r_slot_age[k];
            end
        end
        for (int l = 0; l < trsa_pkg::IDX_W; l++) begin
            for (int k = 0; k < (trsa_pkg::SLOTS_P2 >> (l + 1)); k++) begin
                if (tree_age[l][2*k+1] > tree_age[l][2*k]) begin
                    tree_age[l+1][k] = tree_age[l][2*k+1];
                    tree_idx[l+1][k] = tree_idx[l][2*k+1];
                end else begin
                    tree_age[l+1][k] = tree_age[l][2*k];
                    tree_idx[l+1][k] = tree_idx[l][2*k];
                end
            end
        end
        max_idx = tree_idx[trsa_pkg::IDX_W][0];
    end

    always_comb begin
        n_cmd        = r_cmd;
        n_name       = r_name;
        n_temp       = r_temp;
        n_dflt       = r_dflt;
        n_spill      = r_spill;
        n_slot_name  = r_slot_name;
        n_slot_age   = r_slot_age;
        n_slot_valid = r_slot_valid;
        n_idx        = r_idx;
        n_strobe     = 1'b0;
        n_action     = r_action;
        n_reg        = r_reg;
        n_spill_name = r_spill_name;
        n_last       = r_last;
        case (i_op)
            trsa_pkg::OP_LATCH: begin
                n_cmd   = trsa_pkg::t_cmd'(i_cmd);
                n_name  = trsa_pkg::NAME_BITS'(i_name_id);
                n_temp  = i_is_temp;
                n_dflt  = i_default_reg;
                n_spill = i_spill_on_clear;
            end
            trsa_pkg::OP_DECIDE: begin
                if (is_clear) begin
                    n_idx = '0;
                end else if (!r_temp) begin
                    n_strobe     = 1'b1;
                    n_action     = (r_cmd == trsa_pkg::CMD_LOAD) ?
                                   trsa_pkg::ACT_MEM_DEFAULT : trsa_pkg::ACT_DEFAULT;
                    n_reg        = r_dflt;
                    n_spill_name = '0;
                    n_last       = 1'b1;
                end else if (lookup_only) begin
                    n_strobe     = 1'b1;
                    n_action     = hit ? trsa_pkg::ACT_COPY_SLOT : trsa_pkg::ACT_MEM_DEFAULT;
                    n_reg        = hit ? trsa_pkg::reg_of(hit_idx) : r_dflt;
                    n_spill_name = '0;
                    n_last       = 1'b1;
                end else begin
                    for (int j = 0; j < trsa_pkg::SLOTS; j++) begin
                        if (r_slot_valid[j] && (r_slot_age[j] != trsa_pkg::AGE_MAX)) begin
                            n_slot_age[j] = r_slot_age[j] + 1'b1;
                        end
                    end
                    if (hit) begin
                        n_strobe     = 1'b1;
                        n_action     = trsa_pkg::ACT_HIT;
                        n_reg        = trsa_pkg::reg_of(hit_idx);
                        n_spill_name = '0;
                        n_last       = 1'b1;
                    end else if (has_free) begin
                        n_slot_valid[free_idx] = 1'b1;
                        n_slot_name[free_idx]  = r_name;
                        n_slot_age[free_idx]   = '0;
                        n_strobe               = 1'b1;
                        n_action               = trsa_pkg::ACT_FILL_FREE;
                        n_reg                  = trsa_pkg::reg_of(free_idx);
                        n_spill_name           = '0;
                        n_last                 = 1'b1;
                    end
                end
            end
            trsa_pkg::OP_SEARCH: begin
                n_idx = max_idx;
            end
            trsa_pkg::OP_SPILL: begin
                n_strobe     = 1'b1;
                n_action     = trsa_pkg::ACT_SPILL_VICT;
                n_reg        = trsa_pkg::reg_of(r_idx);
                n_spill_name = 16'(sel_name);
                n_last       = 1'b0;
            end
            trsa_pkg::OP_FILL: begin
                n_slot_name[r_idx] = r_name;
                n_slot_age[r_idx]  = '0;
                n_strobe           = 1'b1;
                n_action           = trsa_pkg::ACT_FILL_VICT;
                n_reg              = trsa_pkg::reg_of(r_idx);
                n_spill_name       = '0;
                n_last             = 1'b1;
            end
            trsa_pkg::OP_WALK: begin
                if (r_slot_valid[r_idx]) begin
                    n_strobe     = 1'b1;
                    n_action     = trsa_pkg::ACT_CLEAR_SPILL;
                    n_reg        = trsa_pkg::reg_of(r_idx);
                    n_spill_name = 16'(sel_name);
                    n_last       = 1'b0;
                end
                n_idx = r_idx + 1'b1;
            end
            trsa_pkg::OP_DONE: begin
                n_slot_valid = '0;
                for (int j = 0; j < trsa_pkg::SLOTS; j++) begin
                    n_slot_age[j] = '0;
                end
                n_strobe     = 1'b1;
                n_action     = trsa_pkg::ACT_CLEAR_DONE;
                n_reg        = '0;
                n_spill_name = '0;
                n_last       = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            for (int j = 0; j < trsa_pkg::SLOTS; j++) begin
                r_slot_age[j] <= '0;
            end
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_slot_valid <= n_slot_valid;
            r_slot_age   <= n_slot_age;
            r_idx        <= n_idx;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_name       <= n_name;
        r_temp       <= n_temp;
        r_dflt       <= n_dflt;
        r_spill      <= n_spill;
        r_slot_name  <= n_slot_name;
        r_action     <= n_action;
        r_reg        <= n_reg;
        r_spill_name <= n_spill_name;
        r_last       <= n_last;
    end

    assign o_status.clear     = is_clear;
    assign o_status.spill     = r_spill;
    assign o_status.full_miss = !is_clear && r_temp && !lookup_only && !hit && !has_free;
    assign o_status.walk_last = (r_idx == trsa_pkg::IDX_W'(trsa_pkg::SLOTS - 1));

    assign o_strobe     = r_strobe;
    assign o_action     = r_action;
    assign o_reg_number = r_reg;
    assign o_spill_name = r_spill_name;
    assign o_last       = r_last;

endmodule

// File: hdl/temp_register_slot_allocator_top.sv
// Top level of the temporary register slot allocator.
// Joins the controller trsa_ctrl and the datapath trsa_datapath. Depends on trsa_pkg.
`timescale 1ns / 1ps

// A 16-slot fully associative table binds temporary names to registers 7-14
// and 17-24 with first-in first-out replacement. A transaction is taken when
// start is high and busy is low; each result appears for one cycle with
// o_strobe high, in the cycle after the step that makes it, and o_last marks the
// final result of a transaction. Results cannot be held off, so the receiver
// must take every strobe. Busy stays high through the decode step alone when a
// transaction hits, fills a free slot or uses the default register; a miss on
// a full table holds busy through decode (age update), search (oldest-slot
// search tree), spill and fill; clear holds it through decode and done, with
// the walk between them when it writes back, which visits one slot per cycle.
// A new transaction may start in the cycle in which the final result of the
// previous one is on the outputs.
module temp_register_slot_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_name_id,
    input  logic        i_is_temp,
    input  logic [4:0]  i_default_reg,
    input  logic        i_spill_on_clear,
    output logic        o_strobe,
    output logic [3:0]  o_action,
    output logic [4:0]  o_reg_number,
    output logic [15:0] o_spill_name,
    output logic        o_last
);

    trsa_pkg::t_dp_status status;
    trsa_pkg::t_dp_op     op;

    trsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_op     (op)
    );

    trsa_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_cmd            (i_cmd),
        .i_name_id        (i_name_id),
        .i_is_temp        (i_is_temp),
        .i_default_reg    (i_default_reg),
        .i_spill_on_clear (i_spill_on_clear),
        .o_status         (status),
        .o_strobe         (o_strobe),
        .o_action         (o_action),
        .o_reg_number     (o_reg_number),
        .o_spill_name     (o_spill_name),
        .o_last           (o_last)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && o_strobe) |-> o_last)
        else $error("non-final result while idle");

    a_spill_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_action == 4'(trsa_pkg::ACT_SPILL_VICT))) |=>
        (o_strobe && (o_action == 4'(trsa_pkg::ACT_FILL_VICT)) &&
         (o_reg_number == $past(o_reg_number))))
        else $error("victim spill not followed by fill of the same register");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_action == 4'(trsa_pkg::ACT_CLEAR_DONE))) |->
        (o_last && (o_reg_number == 5'd0) && (o_spill_name == 16'd0)))
        else $error("malformed clear done result");

endmodule
